[hdl/sha256_byte_stream_hasher_macros.svh]
// Assertion helpers shared by the hasher modules.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hdl/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam int QueueDepth = 4;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] hash_type;

   localparam hash_type InitHash = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LengthOffset = 6'd56;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      begin
         unique case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
         endcase
         return k;
      end
   endfunction
endpackage

[hdl/sha_queue.sv]
`timescale 1ns / 1ps
module sha_queue (
   input  logic             clock,
   input  logic             reset,
   input  sha_pkg::req_type push_item,
   input  logic             push,
   output logic             full,
   output sha_pkg::req_type pop_item,
   output logic             empty,
   input  logic             pop
);
   import sha_pkg::*;
   `include "sha256_byte_stream_hasher_macros.svh"

   localparam int PtrW = $clog2(QueueDepth);

   req_type           slot_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]     count_ff;

   assign full     = (count_ff == (PtrW+1)'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push && !full) wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         if (pop && !empty) rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         count_ff <= count_ff + (PtrW+1)'(push && !full) - (PtrW+1)'(pop && !empty);
      end
   end

   `SHA_ASSERT_IMP(a_count_range, 1'b1, count_ff <= (PtrW+1)'(QueueDepth))
   `SHA_ASSERT_NEXT(a_push_fills, push && !full && !pop, !empty)
   `SHA_ASSERT_NEXT(a_pop_drain, pop && !push && count_ff == 1, empty)
endmodule

[hdl/sha_core.sv]
`timescale 1ns / 1ps
module sha_core (
   input  logic             clock,
   input  logic             reset,
   input  sha_pkg::req_type item,
   input  logic             item_ready,
   output logic             item_take,
   output sha_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_stall
);
   import sha_pkg::*;
   `include "sha256_byte_stream_hasher_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT
   } state_type;

   state_type    state_ff;
   // Block bytes shift in at the bottom, so the oldest byte ends up in the top byte.
   // During the rounds the same register is the sixteen-word message schedule window.
   logic [511:0] blk_ff;
   logic [5:0]   fill_ff;
   logic [60:0]  count_ff;
   hash_type     chain_ff;
   hash_type     v_ff;
   logic [5:0]   round_ff;
   logic         finish_ff;   // padding starts once the current block is compressed
   logic         mark_ff;     // the 0x80 marker has been placed
   logic         tail_ff;     // the block being padded carries the length
   logic [2:0]   emit_ff;
   logic [63:0]  bits_ff;

   word_type   a, e, t1, t2, wn, s0, s1, w0, w1, w9, w14;
   logic [7:0] pad_byte;

   always_comb begin
      priority if (!mark_ff)
         pad_byte = PadByte;
      else if (tail_ff && fill_ff >= LengthOffset)
         pad_byte = bits_ff[63:56];
      else
         pad_byte = 8'h00;
   end

   always_comb begin
      w0  = blk_ff[511:480];
      w1  = blk_ff[479:448];
      w9  = blk_ff[223:192];
      w14 = blk_ff[63:32];
      a   = v_ff[0];
      e   = v_ff[4];
      t1 = v_ff[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_const(round_ff) + w0;
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
      s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
      wn = w0 + s0 + w9 + s1;
   end

   assign item_take = (state_ff == S_IDLE) && item_ready;
   assign rsp_valid = (state_ff == S_EMIT);
   assign rsp_data  = '{digest_word: chain_ff[emit_ff], word_index: emit_ff,
                        last_word: (emit_ff == 3'd7)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         count_ff  <= '0;
         chain_ff  <= InitHash;
         emit_ff   <= '0;
         finish_ff <= 1'b0;
         mark_ff   <= 1'b0;
         tail_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (item_ready) begin
                  if (item.byte_valid) begin
                     blk_ff <= {blk_ff[503:0], item.data_byte};
                     fill_ff <= fill_ff + 6'd1;
                     count_ff <= count_ff + 61'd1;
                  end
                  finish_ff <= item.end_of_message;
                  if (item.byte_valid && fill_ff == 6'd63) begin
                     v_ff <= chain_ff;
                     round_ff <= '0;
                     state_ff <= S_ROUND;
                  end else if (item.end_of_message) begin
                     state_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               // One padding byte per cycle: the marker, zeros, then the length tail.
               blk_ff <= {blk_ff[503:0], pad_byte};
               fill_ff <= fill_ff + 6'd1;
               if (!mark_ff) begin
                  mark_ff <= 1'b1;
                  tail_ff <= (fill_ff < LengthOffset);
                  bits_ff <= {count_ff, 3'b000};
               end else if (tail_ff && fill_ff >= LengthOffset) begin
                  bits_ff <= {bits_ff[55:0], 8'h00};
               end
               if (fill_ff == 6'd63) begin
                  v_ff <= chain_ff;
                  round_ff <= '0;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               v_ff <= {v_ff[6:4], v_ff[3] + t1, v_ff[2:0], t1 + t2};
               blk_ff <= {blk_ff[479:0], wn};
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
               if (mark_ff) begin
                  if (tail_ff) begin
                     emit_ff <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     // The length did not fit after the marker, so a block of zeros and length follows.
                     tail_ff <= 1'b1;
                     state_ff <= S_PAD;
                  end
               end else if (finish_ff) begin
                  state_ff <= S_PAD;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_EMIT: begin
               if (!rsp_stall) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     chain_ff  <= InitHash;
                     count_ff  <= '0;
                     finish_ff <= 1'b0;
                     mark_ff   <= 1'b0;
                     tail_ff   <= 1'b0;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `SHA_ASSERT_IMP(a_emit_no_take, state_ff == S_EMIT, !item_take)
   `SHA_ASSERT_NEXT(a_emit_hold, rsp_valid && rsp_stall, rsp_valid && $stable(emit_ff))
   `SHA_ASSERT_NEXT(a_round_step, state_ff == S_ROUND && round_ff != 6'd63,
                    state_ff == S_ROUND)
endmodule

[hdl/sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps
// SHA-256 over a byte stream.
// Request channel (req_valid/req_stall/req_data): one item carries an optional
// message byte and an end-of-message flag. An item with end set, with or
// without a byte, closes the message.
// Response channel (rsp_valid/rsp_stall/rsp_data): eight items per message,
// digest words 0 to 7, the last one flagged.
// A four-entry input queue decouples the request side from the compression engine,
// so a few items are taken while a block is being compressed.
// Throughput: one byte item per cycle between blocks while the queue holds items; the
// item that completes a block holds the engine through the rounds and the chaining add.
// An end item shifts its padding in one byte per cycle, and each padded block is then
// compressed (rounds, then the chaining add) before the first digest word appears; the
// words then follow one per cycle while the receiver does not stall.
// A stalled response holds its word until taken; nothing further is emitted.
// Synchronous reset restores the initial hash values and empties the queue.
module sha256_byte_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   req_type q_item;
   logic    q_full, q_empty, q_pop;

   assign req_stall = q_full;

   sha_queue u_queue (
      .clock(clock), .reset(reset),
      .push_item(req_data), .push(req_valid), .full(q_full),
      .pop_item(q_item), .empty(q_empty), .pop(q_pop)
   );

   sha_core u_core (
      .clock(clock), .reset(reset),
      .item(q_item), .item_ready(!q_empty), .item_take(q_pop),
      .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
   );
endmodule
